// ===== sv/bht_pkg.sv =====
// ----------------------------------------------------------------------------
// bht_pkg
// Shared constants and the bucket hash for the bucketed hash table.
// ----------------------------------------------------------------------------
package bht_pkg;

  // Default geometry
  localparam int BUCKETS_DEF     = 1024;
  localparam int CHAIN_DEPTH_DEF = 32;

  // Field widths
  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int OP_W   = 2;

  // Hash multiplier
  localparam logic [KEY_W-1:0] HASH_MUL = 32'd23;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Unmasked bucket hash: ((key >> 4) * 23) << 2, wrapping at 32 bits
  function automatic logic [KEY_W-1:0] hash_word(input logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] prod;
    prod = (key >> 4) * HASH_MUL;
    return prod << 2;
  endfunction

endpackage

// ===== sv/bht_in_if.sv =====
// ----------------------------------------------------------------------------
// bht_in_if
// Command channel: opcode, key and value with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bht_in_if;
  logic                        valid;
  logic                        ready;
  logic [bht_pkg::OP_W-1:0]    opcode;
  logic [bht_pkg::KEY_W-1:0]   item_key;
  logic [bht_pkg::VAL_W-1:0]   item_value;

  modport source (output valid, output opcode, output item_key, output item_value,
                  input ready);
  modport sink   (input valid, input opcode, input item_key, input item_value,
                  output ready);
endinterface

// ===== sv/bht_out_if.sv =====
// ----------------------------------------------------------------------------
// bht_out_if
// Response channel: lookup and insert status with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bht_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [bht_pkg::VAL_W-1:0]   found_value;
  logic                        stored;
  logic                        bucket_full;

  modport source (output valid, output found, output found_value, output stored,
                  output bucket_full, input ready);
  modport sink   (input valid, input found, input found_value, input stored,
                  input bucket_full, output ready);
endinterface

// ===== sv/bucketed_hash_table_top.sv =====
// ----------------------------------------------------------------------------
// bucketed_hash_table_top
// Hash table of 32-bit key/value pairs, one bucket per wide memory row.
// ----------------------------------------------------------------------------
// The command is captured in the op registers while the bucket row is read; the
// result is registered in the response registers once the output is free.
// One command at a time: bucket row read, then compare/write-back, before the next is taken.
// A clear command adds a sweep over all BUCKETS rows of the tag/valid memory.
// Reset: synchronous; runs the same sweep before taking commands.
// ----------------------------------------------------------------------------
module bucketed_hash_table_top #(
  parameter int BUCKETS     = bht_pkg::BUCKETS_DEF,
  parameter int CHAIN_DEPTH = bht_pkg::CHAIN_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  bht_in_if.sink    cmd,
  bht_out_if.source rsp
);
  localparam int KW    = bht_pkg::KEY_W;
  localparam int VW    = bht_pkg::VAL_W;
  localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int CD    = CHAIN_DEPTH;
  localparam int A_W   = CD + CD * KW;   // valid bits, then keys
  localparam int B_W   = CD * VW;        // values
  localparam logic [BW-1:0] LAST_ROW = BW'(BUCKETS - 1);

  typedef enum logic [2:0] {
    S_SWEEP = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [BW-1:0]            sweep_cnt;
  logic [bht_pkg::OP_W-1:0] op_code;
  logic [KW-1:0]            op_key;
  logic [VW-1:0]            op_value;
  logic [BW-1:0]            op_idx;

  logic                     out_valid;
  logic                     out_found;
  logic [VW-1:0]            out_found_value;
  logic                     out_stored;
  logic                     out_full;

  logic                     cmd_fire;
  logic                     out_free;
  logic                     exec_fire;
  logic [KW-1:0]            cmd_hash;
  logic [BW-1:0]            cmd_idx;

  logic [A_W-1:0]           a_rd;
  logic [B_W-1:0]           b_rd;
  logic [A_W-1:0]           a_new;
  logic [B_W-1:0]           b_new;
  logic                     a_we;
  logic [BW-1:0]            a_waddr;
  logic [A_W-1:0]           a_wdata;
  logic                     b_we;

  logic [CD-1:0]            valid_v;
  logic [CD-1:0]            free_v;
  logic [CD-1:0]            free_first;
  logic [CD-1:0]            match_v;
  logic [CD-1:0]            match_first;
  logic [VW-1:0]            hit_value;

  logic                     res_found;
  logic [VW-1:0]            res_found_value;
  logic                     res_stored;
  logic                     res_full;
  logic                     do_insert;

  // Handshake
  assign cmd.ready = (state == S_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign exec_fire = (state == S_EXEC) && out_free;

  // Bucket index of the incoming key
  assign cmd_hash = bht_pkg::hash_word(cmd.item_key);
  assign cmd_idx  = BW'(cmd_hash & KW'(BUCKETS - 1));

  // Bucket row compare and update
  always_comb begin
    valid_v     = a_rd[CD-1:0];
    free_v      = ~valid_v;
    free_first  = free_v & (~free_v + CD'(1));
    for (int s = 0; s < CD; s++) begin
      match_v[s] = valid_v[s] && (a_rd[CD + s*KW +: KW] == op_key);
    end
    match_first = match_v & (~match_v + CD'(1));
    hit_value   = '0;
    a_new       = a_rd;
    b_new       = b_rd;
    a_new[CD-1:0] = valid_v | free_first;
    for (int s = 0; s < CD; s++) begin
      hit_value = hit_value | (b_rd[s*VW +: VW] & {VW{match_first[s]}});
      if (free_first[s]) begin
        a_new[CD + s*KW +: KW] = op_key;
        b_new[s*VW +: VW]      = op_value;
      end
    end
  end

  // Result per opcode; unused fields stay zero
  always_comb begin
    res_found       = 1'b0;
    res_found_value = '0;
    res_stored      = 1'b0;
    res_full        = 1'b0;
    do_insert       = 1'b0;
    case (op_code)
      bht_pkg::OP_INSERT: begin
        res_stored = |free_v;
        res_full   = ~|free_v;
        do_insert  = |free_v;
      end
      bht_pkg::OP_LOOKUP: begin
        res_found       = |match_v;
        res_found_value = hit_value;
      end
      default: ;
    endcase
  end

  // Memory write selection: sweep clears valid bits, insert writes back the row
  assign a_we    = (state == S_SWEEP) || (exec_fire && do_insert);
  assign a_waddr = (state == S_SWEEP) ? sweep_cnt : op_idx;
  assign a_wdata = (state == S_SWEEP) ? '0 : a_new;
  assign b_we    = exec_fire && do_insert;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_SWEEP: begin
        if (sweep_cnt == LAST_ROW) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_fire) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          state_next = (op_code == bht_pkg::OP_CLEAR) ? S_SWEEP : S_IDLE;
        end
      end
      default: state_next = S_SWEEP;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      sweep_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SWEEP) begin
        sweep_cnt <= sweep_cnt + BW'(1);
      end else begin
        sweep_cnt <= '0;
      end
      if (exec_fire) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Command and result payload registers
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      op_code  <= cmd.opcode;
      op_key   <= cmd.item_key;
      op_value <= cmd.item_value;
      op_idx   <= cmd_idx;
    end
    if (exec_fire) begin
      out_found       <= res_found;
      out_found_value <= res_found_value;
      out_stored      <= res_stored;
      out_full        <= res_full;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.found       = out_found;
  assign rsp.found_value = out_found_value;
  assign rsp.stored      = out_stored;
  assign rsp.bucket_full = out_full;

  // Valid bits and keys, one bucket per row
  bht_ram #(.WIDTH(A_W), .DEPTH(BUCKETS)) u_key_ram (
    .clk     (clk),
    .wr_en   (a_we),
    .wr_addr (a_waddr),
    .wr_data (a_wdata),
    .rd_en   (cmd_fire),
    .rd_addr (cmd_idx),
    .rd_data (a_rd)
  );

  // Values, one bucket per row
  bht_ram #(.WIDTH(B_W), .DEPTH(BUCKETS)) u_val_ram (
    .clk     (clk),
    .wr_en   (b_we),
    .wr_addr (op_idx),
    .wr_data (b_new),
    .rd_en   (cmd_fire),
    .rd_addr (cmd_idx),
    .rd_data (b_rd)
  );
endmodule

// ===== sv/bht_ram.sv =====
// ----------------------------------------------------------------------------
// bht_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [WIDTH-1:0]     rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ===== sv/bht_checker.sv =====
// ----------------------------------------------------------------------------
// bht_checker
// Port-level checks for the bucketed hash table, bound to the top level.
// ----------------------------------------------------------------------------
module bht_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      cmd_valid,
  input logic                      cmd_ready,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic                      found,
  input logic [bht_pkg::VAL_W-1:0] found_value,
  input logic                      stored,
  input logic                      bucket_full
);
  // A stalled response stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // A stalled response keeps its payload
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(found) && $stable(found_value)
                                && $stable(stored) && $stable(bucket_full))
    else $error("response payload changed while stalled");

  // One command in flight: no transfer right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while previous one is in flight");

  // Lookup and insert status never mix, stored and full exclude each other
  a_status_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(found && (stored || bucket_full)) && !(stored && bucket_full))
    else $error("inconsistent response status");

  // A miss returns zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !found |-> found_value == '0)
    else $error("nonzero value on a miss");
endmodule

bind bucketed_hash_table_top bht_checker u_bht_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .found       (rsp.found),
  .found_value (rsp.found_value),
  .stored      (rsp.stored),
  .bucket_full (rsp.bucket_full)
);
